### rtl/core/mbre_pkg.sv
// ---------------------------------------------------------------------------
// mbre_pkg
// Shared types and constants for the monochrome bitmap row expander.
// ---------------------------------------------------------------------------
package mbre_pkg;

    // fixed field widths
    localparam int unsigned ICON_WIDTH_W = 6;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned ROW_BITS_W   = 32;
    localparam int unsigned COLOUR_W     = 16;
    localparam int unsigned ADDR_W       = 16;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned BIT_SEL_W    = 5;
    localparam int unsigned S_TDATA_W    = 40;
    localparam int unsigned M_TDATA_W    = 32;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ICON_WIDTH      = 3'd0,
        REG_ICON_HEIGHT     = 3'd1,
        REG_CONTAINER_WIDTH = 3'd2,
        REG_X_OFFSET        = 3'd3,
        REG_Y_OFFSET        = 3'd4,
        REG_FG_COLOUR       = 3'd5,
        REG_BG_COLOUR       = 3'd6
    } reg_idx_t;

    // what one row item turns into
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_PIXELS = 2'd2
    } item_kind_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [ICON_WIDTH_W-1:0] icon_width;
        logic [BYTE_W-1:0]       icon_height;
        logic [BYTE_W-1:0]       container_width;
        logic [BYTE_W-1:0]       x_offset;
        logic [BYTE_W-1:0]       y_offset;
        logic [COLOUR_W-1:0]     fg_colour;
        logic [COLOUR_W-1:0]     bg_colour;
    } cfg_t;

    // one row item
    typedef struct packed {
        logic [BYTE_W-1:0]     row_index;
        logic [ROW_BITS_W-1:0] row_bits;
    } row_item_t;

    // handshake between input register and expander
    typedef struct packed {
        logic pop;
    } item_hs_t;

endpackage

### rtl/core/mbre_cfg_regs.sv
// ---------------------------------------------------------------------------
// mbre_cfg_regs
// Configuration register file written through the cfg write channel.
// ---------------------------------------------------------------------------
module mbre_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbre_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mbre_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mbre_pkg::cfg_t                      cfg
);

    mbre_pkg::cfg_t cfg_reg;

    // writes always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (mbre_pkg::reg_idx_t'(cfg_index))
                mbre_pkg::REG_ICON_WIDTH: begin
                    cfg_reg.icon_width <= cfg_data[mbre_pkg::ICON_WIDTH_W-1:0];
                end
                mbre_pkg::REG_ICON_HEIGHT: begin
                    cfg_reg.icon_height <= cfg_data[mbre_pkg::BYTE_W-1:0];
                end
                mbre_pkg::REG_CONTAINER_WIDTH: begin
                    cfg_reg.container_width <= cfg_data[mbre_pkg::BYTE_W-1:0];
                end
                mbre_pkg::REG_X_OFFSET: begin
                    cfg_reg.x_offset <= cfg_data[mbre_pkg::BYTE_W-1:0];
                end
                mbre_pkg::REG_Y_OFFSET: begin
                    cfg_reg.y_offset <= cfg_data[mbre_pkg::BYTE_W-1:0];
                end
                mbre_pkg::REG_FG_COLOUR: begin
                    cfg_reg.fg_colour <= cfg_data;
                end
                mbre_pkg::REG_BG_COLOUR: begin
                    cfg_reg.bg_colour <= cfg_data;
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

### rtl/core/mbre_in_reg.sv
// ---------------------------------------------------------------------------
// mbre_in_reg
// Input register holding the row item that is being expanded.
// ---------------------------------------------------------------------------
module mbre_in_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mbre_pkg::row_item_t   s_item,
    input  logic                  pop,
    output logic                  item_valid,
    output mbre_pkg::row_item_t   item
);

    logic                valid_reg;
    logic                valid_next;
    mbre_pkg::row_item_t item_reg;

    // free, or emptied by the expander in this cycle
    assign s_tready   = !valid_reg || pop;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/core/mbre_expander.sv
// ---------------------------------------------------------------------------
// mbre_expander
// Walks the held row one pixel per transaction into the result register.
// ---------------------------------------------------------------------------
module mbre_expander #(
    parameter int unsigned SMALL_ROW_WIDTH = 16,
    parameter int unsigned MAX_ROW_WIDTH   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mbre_pkg::cfg_t                      cfg,
    input  mbre_pkg::row_item_t                 item,
    input  logic                                item_valid,
    output mbre_pkg::item_hs_t                  hs,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mbre_pkg::ADDR_W-1:0]         m_address,
    output logic [mbre_pkg::COLOUR_W-1:0]       m_colour,
    output logic                                m_last,
    output logic                                m_status
);

    localparam int unsigned COL_W   = $clog2(MAX_ROW_WIDTH);
    localparam int unsigned CNT_W   = mbre_pkg::ICON_WIDTH_W;
    localparam int unsigned SUM_W   = mbre_pkg::BYTE_W + 1;
    localparam int unsigned PROD_W  = SUM_W + mbre_pkg::BYTE_W;
    localparam logic [CNT_W-1:0] SMALL_CNT = CNT_W'(SMALL_ROW_WIDTH);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_ROW_WIDTH);
    localparam logic [CNT_W-1:0] SMALL_TOP = CNT_W'(SMALL_ROW_WIDTH - 1);
    localparam logic [CNT_W-1:0] MAX_TOP   = CNT_W'(MAX_ROW_WIDTH - 1);

    logic [COL_W-1:0]                 col_reg;
    logic [COL_W-1:0]                 col_next;
    logic                             valid_reg;
    logic                             valid_next;
    logic [mbre_pkg::ADDR_W-1:0]      addr_reg;
    logic [mbre_pkg::ADDR_W-1:0]      addr_next;
    logic [mbre_pkg::COLOUR_W-1:0]    colour_reg;
    logic [mbre_pkg::COLOUR_W-1:0]    colour_next;
    logic                             last_reg;
    logic                             last_next;
    logic                             status_reg;
    logic                             status_next;

    mbre_pkg::item_kind_t             kind;
    logic [CNT_W-1:0]                 count;
    logic [CNT_W-1:0]                 top;
    logic [CNT_W-1:0]                 col_ext;
    logic [CNT_W-1:0]                 bit_sel;
    logic [SUM_W-1:0]                 place_sum;
    logic [SUM_W-1:0]                 row_sum;
    logic [PROD_W-1:0]                row_prod;
    logic [mbre_pkg::ADDR_W-1:0]      base;
    logic                             pix_set;
    logic                             col_last;
    logic                             out_adv;
    logic                             pop;

    // classify the held item
    always_comb begin
        place_sum = SUM_W'(cfg.x_offset) + SUM_W'(cfg.icon_width);
        if (cfg.icon_width == '0 || cfg.icon_height == '0 || cfg.container_width == '0) begin
            kind = mbre_pkg::KIND_NONE;
        end else if (place_sum > SUM_W'(cfg.container_width)) begin
            kind = mbre_pkg::KIND_ERROR;
        end else if (item.row_index >= cfg.icon_height) begin
            kind = mbre_pkg::KIND_NONE;
        end else begin
            kind = mbre_pkg::KIND_PIXELS;
        end
    end

    // pixel count and first bit position
    always_comb begin
        if (cfg.icon_width <= SMALL_CNT) begin
            count = cfg.icon_width;
            top   = SMALL_TOP;
        end else begin
            count = (cfg.icon_width > MAX_CNT) ? MAX_CNT : cfg.icon_width;
            top   = MAX_TOP;
        end
        col_ext  = CNT_W'(col_reg);
        bit_sel  = top - col_ext;
        pix_set  = item.row_bits[bit_sel[mbre_pkg::BIT_SEL_W-1:0]];
        col_last = (col_ext == count - CNT_W'(1));
    end

    // row base address, wrapping at 16 bits
    always_comb begin
        row_sum  = SUM_W'(item.row_index) + SUM_W'(cfg.y_offset);
        row_prod = PROD_W'(row_sum) * PROD_W'(cfg.container_width);
        base     = row_prod[mbre_pkg::ADDR_W-1:0]
                 + mbre_pkg::ADDR_W'(cfg.x_offset);
    end

    assign out_adv = !valid_reg || m_ready;

    // result and item bookkeeping
    always_comb begin
        valid_next  = valid_reg;
        addr_next   = addr_reg;
        colour_next = colour_reg;
        last_next   = last_reg;
        status_next = status_reg;
        col_next    = col_reg;
        pop         = 1'b0;
        if (out_adv) begin
            valid_next = 1'b0;
            if (item_valid) begin
                case (kind)
                    mbre_pkg::KIND_ERROR: begin
                        valid_next  = 1'b1;
                        addr_next   = '0;
                        colour_next = '0;
                        last_next   = 1'b1;
                        status_next = 1'b1;
                        pop         = 1'b1;
                        col_next    = '0;
                    end
                    mbre_pkg::KIND_PIXELS: begin
                        valid_next  = 1'b1;
                        addr_next   = base + mbre_pkg::ADDR_W'(col_reg);
                        colour_next = pix_set ? cfg.fg_colour
                                              : cfg.bg_colour;
                        last_next   = col_last;
                        status_next = 1'b0;
                        pop         = col_last;
                        col_next    = col_last ? '0 : col_reg + COL_W'(1);
                    end
                    default: begin
                        pop      = 1'b1;
                        col_next = '0;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            col_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            col_reg   <= col_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        colour_reg <= colour_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign hs.pop    = pop;
    assign m_valid   = valid_reg;
    assign m_address = addr_reg;
    assign m_colour  = colour_reg;
    assign m_last    = last_reg;
    assign m_status  = status_reg;

    // an error result is a single, final, zeroed transaction
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && status_reg) |-> (last_reg && addr_reg == '0 && colour_reg == '0))
        else $error("error result not final or not zeroed");

    // a row part-way through keeps its item held
    a_row_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg != '0) |-> item_valid)
        else $error("column counter running without a held row");

    // column counter stays inside the row
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg != '0) |-> (CNT_W'(col_reg) < count))
        else $error("column counter beyond pixel count");

    // consecutive pixels of one row step the address by one
    a_addr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_adv && valid_next && !status_next && col_reg != '0)
        |=> (addr_reg == $past(base) + mbre_pkg::ADDR_W'($past(col_reg))))
        else $error("pixel address out of step");

endmodule

### rtl/core/mono_bitmap_row_expander.sv
// ---------------------------------------------------------------------------
// mono_bitmap_row_expander
// Expands 1-bit icon rows into framebuffer pixel writes.
// ---------------------------------------------------------------------------
//  channel  | direction | payload
//  s_       | in        | tdata: row_index[7:0], row_bits[39:8]
//  m_       | out       | tdata: pixel_address[15:0], pixel_colour[31:16];
//           |           | tlast: last_pixel; tuser: status
//  cfg_     | in        | cfg_index register number, cfg_data value
//
//  While m_tready does not stall, a row gives one result transaction per
//  cycle (icon_width pixels, at most MAX_ROW_WIDTH, counted by the column
//  counter, or one error transaction), and rows giving no result stream at
//  one per cycle. The base address multiply sits in the result register path.
//  Reset is synchronous on aresetn; control and setup registers clear to zero.
//  m_tready low holds the result register and then the input register.
// ---------------------------------------------------------------------------
module mono_bitmap_row_expander #(
    parameter int unsigned SMALL_ROW_WIDTH = 16,
    parameter int unsigned MAX_ROW_WIDTH   = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // row_index [7:0], row_bits [39:8]
    input  logic [mbre_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_address [15:0], pixel_colour [31:16]
    output logic [mbre_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // status [0]
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mbre_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbre_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mbre_pkg::cfg_t                    cfg;
    mbre_pkg::row_item_t               s_item;
    mbre_pkg::row_item_t               item;
    mbre_pkg::item_hs_t                hs;
    logic                              item_valid;
    logic [mbre_pkg::ADDR_W-1:0]       m_address;
    logic [mbre_pkg::COLOUR_W-1:0]     m_colour;

    // unpack the input transaction
    assign s_item.row_index = s_tdata[mbre_pkg::BYTE_W-1:0];
    assign s_item.row_bits  = s_tdata[mbre_pkg::BYTE_W +: mbre_pkg::ROW_BITS_W];

    mbre_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbre_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .pop        (hs.pop),
        .item_valid (item_valid),
        .item       (item)
    );

    mbre_expander #(
        .SMALL_ROW_WIDTH (SMALL_ROW_WIDTH),
        .MAX_ROW_WIDTH   (MAX_ROW_WIDTH)
    ) u_expander (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item       (item),
        .item_valid (item_valid),
        .hs         (hs),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_address  (m_address),
        .m_colour   (m_colour),
        .m_last     (m_tlast),
        .m_status   (m_tuser)
    );

    // pack the result transaction
    assign m_tdata = {m_colour, m_address};

endmodule

### tb/sv/mono_bitmap_row_expander_test.sv
// ---------------------------------------------------------------------------
// mono_bitmap_row_expander_test
// Drives icon rows and register writes into the row expander, predicts the
// pixel writes of each row and checks every result transaction in order.
// ---------------------------------------------------------------------------
module mono_bitmap_row_expander_test;

    localparam int unsigned SMALL_ROW     = 16;
    localparam int unsigned MAX_ROW       = 32;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          WATCHDOG_MAX  = 1000;
    localparam int          RANDOM_PHASES = 13;
    localparam int          ROWS_PER_PHASE = 26;
    localparam int          DIRECTED_STEPS = 43;

    // one expected pixel write, or the placement error
    typedef struct packed {
        logic [mbre_pkg::ADDR_W-1:0]   addr;
        logic [mbre_pkg::COLOUR_W-1:0] colour;
        logic                          last;
        logic                          status;
    } pixel_write_t;

    localparam pixel_write_t PLACEMENT_ERROR_WRITE = '{16'd0, 16'd0, 1'b1, 1'b1};

    // how a directed row is checked
    typedef enum logic [1:0] {
        FROM_PREDICTOR  = 2'd0,
        NO_RESULT       = 2'd1,
        PLACEMENT_ERROR = 2'd2
    } expect_kind_t;

    typedef struct packed {
        logic                            is_write;
        mbre_pkg::reg_idx_t              reg_sel;
        logic [mbre_pkg::CFG_DATA_W-1:0] value;
        logic [mbre_pkg::BYTE_W-1:0]     row;
        logic [mbre_pkg::ROW_BITS_W-1:0] bits;
        expect_kind_t                    kind;
    } directed_step_t;

    // directed plan: register writes and rows, walked in order
    directed_step_t directed_plan [DIRECTED_STEPS] = '{
        // after reset every size is zero
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'hFFFF_FFFF, NO_RESULT},
        '{1'b1, mbre_pkg::REG_ICON_WIDTH,      16'd16,   8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_ICON_HEIGHT,     16'd8,    8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_CONTAINER_WIDTH, 16'd255,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_FG_COLOUR,       16'hFFFF, 8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_BG_COLOUR,       16'h0000, 8'd0,   32'd0,  FROM_PREDICTOR},
        // narrow row, upper half of the word ignored
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'h0000_A5C3, FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd7,   32'hFFFF_0000, FROM_PREDICTOR},
        // row index at and beyond the height
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd8,   32'hFFFF_FFFF, NO_RESULT},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd255, 32'hFFFF_FFFF, NO_RESULT},
        // icon overhangs the container, error wins over row range
        '{1'b1, mbre_pkg::REG_X_OFFSET,        16'd240,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'hA5A5_A5A5, PLACEMENT_ERROR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd200, 32'hA5A5_A5A5, PLACEMENT_ERROR},
        // icon exactly fills the container
        '{1'b1, mbre_pkg::REG_X_OFFSET,        16'd239,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd3,   32'h0000_5A5A, FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_X_OFFSET,        16'd255,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd1,   32'hFFFF_FFFF, PLACEMENT_ERROR},
        // full 32-pixel rows, row base wraps past 65535
        '{1'b1, mbre_pkg::REG_X_OFFSET,        16'd0,    8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_ICON_WIDTH,      16'd32,   8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_ICON_HEIGHT,     16'd255,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_Y_OFFSET,        16'd255,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd254, 32'h8000_0001, FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'hFFFF_0000, FROM_PREDICTOR},
        // width beyond 32 saturates, placement uses the raw width
        '{1'b1, mbre_pkg::REG_ICON_WIDTH,      16'd63,   8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd1,   32'h1234_5678, FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_X_OFFSET,        16'd200,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd1,   32'h0000_0000, PLACEMENT_ERROR},
        '{1'b1, mbre_pkg::REG_X_OFFSET,        16'd0,    8'd0,   32'd0,  FROM_PREDICTOR},
        // just over the narrow limit reads the 32-bit word
        '{1'b1, mbre_pkg::REG_ICON_WIDTH,      16'd17,   8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd2,   32'hDEAD_BEEF, FROM_PREDICTOR},
        // single pixel rows with swapped colours
        '{1'b1, mbre_pkg::REG_ICON_WIDTH,      16'd1,    8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_FG_COLOUR,       16'h0000, 8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_BG_COLOUR,       16'hFFFF, 8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'h0000_8000, FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'h0000_7FFF, FROM_PREDICTOR},
        // zero height, zero container (beats the overhang), zero width
        '{1'b1, mbre_pkg::REG_ICON_HEIGHT,     16'd0,    8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'hFFFF_FFFF, NO_RESULT},
        '{1'b1, mbre_pkg::REG_ICON_HEIGHT,     16'd255,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_CONTAINER_WIDTH, 16'd0,    8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'hFFFF_FFFF, NO_RESULT},
        '{1'b1, mbre_pkg::REG_CONTAINER_WIDTH, 16'd255,  8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b1, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'd0,  FROM_PREDICTOR},
        '{1'b0, mbre_pkg::REG_ICON_WIDTH,      16'd0,    8'd0,   32'hFFFF_FFFF, NO_RESULT}
    };

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic [mbre_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [mbre_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [mbre_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mbre_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    mbre_pkg::cfg_t setup_mirror = '0;
    pixel_write_t   pending_writes [$];
    int             mismatches      = 0;
    int             source_idle_pct = 0;
    int             sink_idle_pct   = 0;
    int             stall_left      = 0;
    int             idle_cycles     = 0;
    bit             rows_sent       = 1'b0;

    mono_bitmap_row_expander #(
        .SMALL_ROW_WIDTH(SMALL_ROW),
        .MAX_ROW_WIDTH  (MAX_ROW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // register mirror update
    function automatic void mirror_write(input mbre_pkg::reg_idx_t idx,
                                         input logic [mbre_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            mbre_pkg::REG_ICON_WIDTH:
                setup_mirror.icon_width = value[mbre_pkg::ICON_WIDTH_W-1:0];
            mbre_pkg::REG_ICON_HEIGHT:
                setup_mirror.icon_height = value[mbre_pkg::BYTE_W-1:0];
            mbre_pkg::REG_CONTAINER_WIDTH:
                setup_mirror.container_width = value[mbre_pkg::BYTE_W-1:0];
            mbre_pkg::REG_X_OFFSET:
                setup_mirror.x_offset = value[mbre_pkg::BYTE_W-1:0];
            mbre_pkg::REG_Y_OFFSET:
                setup_mirror.y_offset = value[mbre_pkg::BYTE_W-1:0];
            mbre_pkg::REG_FG_COLOUR:
                setup_mirror.fg_colour = value;
            mbre_pkg::REG_BG_COLOUR:
                setup_mirror.bg_colour = value;
            default: ;
        endcase
    endfunction

    // pixel writes that one row gives under the mirrored setup
    function automatic void expand_row(input logic [mbre_pkg::BYTE_W-1:0] row,
                                       input logic [mbre_pkg::ROW_BITS_W-1:0] bits);
        int unsigned  width, height, cw, xo, yo, count, top, base;
        pixel_write_t w;
        width  = setup_mirror.icon_width;
        height = setup_mirror.icon_height;
        cw     = setup_mirror.container_width;
        xo     = setup_mirror.x_offset;
        yo     = setup_mirror.y_offset;
        if (width == 0 || height == 0 || cw == 0)
            return;
        if (xo + width > cw) begin
            pending_writes.push_back(PLACEMENT_ERROR_WRITE);
            return;
        end
        if (row >= height)
            return;
        if (width <= SMALL_ROW) begin
            count = width;
            top   = SMALL_ROW - 1;
        end else begin
            count = (width > MAX_ROW) ? MAX_ROW : width;
            top   = MAX_ROW - 1;
        end
        base = ((row + yo) * cw) & 32'hFFFF;
        base = (base + xo) & 32'hFFFF;
        for (int unsigned c = 0; c < count; c++) begin
            w.addr   = mbre_pkg::ADDR_W'((base + c) & 32'hFFFF);
            w.colour = bits[top - c] ? setup_mirror.fg_colour
                                     : setup_mirror.bg_colour;
            w.last   = (c + 1 == count);
            w.status = 1'b0;
            pending_writes.push_back(w);
        end
    endfunction

    // one register write transaction, valid left high for a following write
    task automatic write_reg(input mbre_pkg::reg_idx_t idx,
                             input logic [mbre_pkg::CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        mirror_write(idx, value);
    endtask

    // one row transaction, with an optional idle burst in front
    task automatic send_row(input logic [mbre_pkg::BYTE_W-1:0] row,
                            input logic [mbre_pkg::ROW_BITS_W-1:0] bits);
        cfg_valid <= 1'b0;
        if (source_idle_pct != 0 && $urandom_range(0, 99) < source_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge aclk);
        end
        s_tdata  <= {bits, row};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        rows_sent = 1'b1;
    endtask

    // drain: all expected writes seen, then let rows with no result retire
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
        rows_sent = 1'b0;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stall bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_tready <= (stall_left == 1);
            stall_left--;
        end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checking against the oldest expectation
    always @(posedge aclk) begin : result_check
        pixel_write_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[31:16], m_tlast, m_tuser};
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %h %h %b %b",
                         $time, "got addr/colour/last/status",
                         got.addr, got.colour, got.last, got.status);
                mismatches++;
            end else begin
                want = pending_writes.pop_front();
                check_field("pixel_address", want.addr, got.addr);
                check_field("pixel_colour", want.colour, got.colour);
                check_field("last_pixel", want.last, got.last);
                check_field("status", want.status, got.status);
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin : stimulus
        directed_step_t                  step;
        int unsigned                     width, height, cw, xo;
        logic [mbre_pkg::CFG_DATA_W-1:0] reg_values [7];
        logic [mbre_pkg::BYTE_W-1:0]     row;
        logic [mbre_pkg::ROW_BITS_W-1:0] bits;

        repeat (8)
            @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        source_idle_pct = 20;
        sink_idle_pct   = 20;
        for (int i = 0; i < DIRECTED_STEPS; i++) begin
            step = directed_plan[i];
            if (step.is_write) begin
                if (rows_sent)
                    wait_idle();
                write_reg(step.reg_sel, step.value);
            end else begin
                send_row(step.row, step.bits);
                case (step.kind)
                    NO_RESULT:       ;
                    PLACEMENT_ERROR: pending_writes.push_back(PLACEMENT_ERROR_WRITE);
                    default:         expand_row(step.row, step.bits);
                endcase
            end
        end

        // random phases, each with a fresh setup; the last ones run without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase >= RANDOM_PHASES - 2) begin
                source_idle_pct = 0;
                sink_idle_pct   = 0;
            end else begin
                source_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
                sink_idle_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            end
            wait_idle();

            // mostly well-placed icons, now and then zero sizes or overhangs
            case ($urandom_range(0, 9))
                0:       width = $urandom_range(0, 63);
                1:       width = $urandom_range(33, 63);
                default: width = $urandom_range(1, 32);
            endcase
            if ($urandom_range(0, 11) == 0)
                cw = $urandom_range(0, 255);
            else
                cw = $urandom_range((width == 0) ? 1 : width, 255);
            if (cw >= width && $urandom_range(0, 99) < 85)
                xo = $urandom_range(0, cw - width);
            else
                xo = $urandom_range(0, 255);
            case ($urandom_range(0, 11))
                0:       height = 0;
                1, 2, 3: height = $urandom_range(1, 8);
                default: height = $urandom_range(1, 255);
            endcase
            reg_values[mbre_pkg::REG_ICON_WIDTH]      = mbre_pkg::CFG_DATA_W'(width);
            reg_values[mbre_pkg::REG_ICON_HEIGHT]     = mbre_pkg::CFG_DATA_W'(height);
            reg_values[mbre_pkg::REG_CONTAINER_WIDTH] = mbre_pkg::CFG_DATA_W'(cw);
            reg_values[mbre_pkg::REG_X_OFFSET]        = mbre_pkg::CFG_DATA_W'(xo);
            reg_values[mbre_pkg::REG_Y_OFFSET]        =
                mbre_pkg::CFG_DATA_W'($urandom_range(0, 255));
            reg_values[mbre_pkg::REG_FG_COLOUR]       = mbre_pkg::CFG_DATA_W'($urandom);
            reg_values[mbre_pkg::REG_BG_COLOUR]       = mbre_pkg::CFG_DATA_W'($urandom);
            for (int r = 0; r < 7; r++)
                write_reg(mbre_pkg::reg_idx_t'(r), reg_values[r]);

            // rows mostly inside the icon
            for (int n = 0; n < ROWS_PER_PHASE; n++) begin
                if (height != 0 && $urandom_range(0, 9) != 0)
                    row = mbre_pkg::BYTE_W'($urandom_range(0, height - 1));
                else
                    row = mbre_pkg::BYTE_W'($urandom_range(0, 255));
                bits = $urandom;
                send_row(row, bits);
                expand_row(row, bits);
            end
        end

        // drain and report
        wait_idle();
        if (pending_writes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_writes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/mbre_pkg.sv
rtl/core/mbre_cfg_regs.sv
rtl/core/mbre_in_reg.sv
rtl/core/mbre_expander.sv
rtl/core/mono_bitmap_row_expander.sv
tb/sv/mono_bitmap_row_expander_test.sv
